// ===== rtl/vht_pkg.sv =====
// Package for the versioned handle table: operation and status codes,
// controller state and the slot-map command/status structs. No dependencies.
package vht_pkg;

   typedef enum logic [2:0] {
      OP_ADD         = 3'd0,
      OP_GET         = 3'd1,
      OP_REMOVE      = 3'd2,
      OP_REPLACE     = 3'd3,
      OP_MAKE_WEAK   = 3'd4,
      OP_TRY_LOOKUP  = 3'd5
   } opcode_type;

   typedef enum logic [2:0] {
      STS_OK         = 3'd0,
      STS_RANGE      = 3'd1,
      STS_UNUSED     = 3'd2,
      STS_MISMATCH   = 3'd3,
      STS_FULL       = 3'd4,
      STS_STALE      = 3'd5
   } status_type;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   typedef struct packed {
      logic claim;
      logic release_slot;
   } slot_cmd_type;

   typedef struct packed {
      logic scanning;
      logic used;
   } slot_stat_type;

   // slots examined per cycle by the free-slot scan (power of two)
   localparam int SCAN_WIDTH = 8;
   localparam int SCAN_SEL_BITS = 3;

endpackage

// ===== rtl/vht_slot_map.sv =====
// Slot occupancy map: use bitmap, grown count and lowest free slot.
// Rescans for the next free slot a chunk per cycle after a claim. Uses vht_pkg.
module vht_slot_map
   import vht_pkg::*;
#(
   parameter int SLOT_COUNT = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  slot_cmd_type                      cmd,
   input  logic [$clog2(SLOT_COUNT)-1:0]     slot_index,
   output slot_stat_type                     stat,
   output logic [$clog2(SLOT_COUNT+1)-1:0]   hole,
   output logic [$clog2(SLOT_COUNT+1)-1:0]   grown
);

   localparam int AW  = $clog2(SLOT_COUNT);
   localparam int GW  = $clog2(SLOT_COUNT + 1);
   localparam int NCH = (SLOT_COUNT + SCAN_WIDTH - 1) / SCAN_WIDTH;
   localparam int PW  = NCH * SCAN_WIDTH;
   localparam int CHW = (NCH > 1) ? $clog2(NCH) : 1;
   localparam int PSW = $clog2(PW + 1) + 1;

   logic [SLOT_COUNT-1:0] used_ff, used_in;
   logic [GW-1:0]         hole_ff, hole_in;
   logic [GW-1:0]         grown_ff, grown_in;
   logic                  scanning_ff, scanning_in;
   logic [GW-1:0]         from_ff, from_in;
   logic [CHW-1:0]        chunk_ff, chunk_in;

   logic [PW-1:0]         used_pad;
   logic [SCAN_WIDTH-1:0] chunks [NCH];
   logic [SCAN_WIDTH-1:0] chunk_bits;
   logic                  found;
   logic [PSW-1:0]        pick_pos;
   logic [PSW-1:0]        bit_pos;
   logic [GW-1:0]         next_from;

   always_comb begin
      used_pad = '1;
      used_pad[SLOT_COUNT-1:0] = used_ff;
      for (int c = 0; c < NCH; c++) begin
         chunks[c] = used_pad[c*SCAN_WIDTH +: SCAN_WIDTH];
      end
   end

   assign chunk_bits = chunks[chunk_ff];

   // lowest free slot in the current chunk at or above the scan start
   always_comb begin
      found    = 1'b0;
      pick_pos = '0;
      bit_pos  = '0;
      for (int j = 0; j < SCAN_WIDTH; j++) begin
         bit_pos = PSW'({chunk_ff, SCAN_SEL_BITS'(j)});
         if (!found && !chunk_bits[j] && (bit_pos >= PSW'(from_ff))) begin
            found    = 1'b1;
            pick_pos = bit_pos;
         end
      end
   end

   assign next_from = hole_ff + 1'b1;

   always_comb begin
      used_in     = used_ff;
      hole_in     = hole_ff;
      grown_in    = grown_ff;
      scanning_in = scanning_ff;
      from_in     = from_ff;
      chunk_in    = chunk_ff;
      if (scanning_ff) begin
         if (found) begin
            hole_in     = GW'(pick_pos);
            scanning_in = 1'b0;
         end else if (chunk_ff == CHW'(NCH - 1)) begin
            hole_in     = GW'(SLOT_COUNT);
            scanning_in = 1'b0;
         end else begin
            chunk_in = chunk_ff + 1'b1;
         end
      end else if (cmd.claim) begin
         used_in[hole_ff[AW-1:0]] = 1'b1;
         if (hole_ff == grown_ff) begin
            grown_in = next_from;
         end
         if (next_from == GW'(SLOT_COUNT)) begin
            hole_in = GW'(SLOT_COUNT);
         end else begin
            scanning_in = 1'b1;
            from_in     = next_from;
            chunk_in    = CHW'(next_from >> SCAN_SEL_BITS);
         end
      end else if (cmd.release_slot) begin
         used_in[slot_index] = 1'b0;
         if (GW'(slot_index) < hole_ff) begin
            hole_in = GW'(slot_index);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff     <= '0;
         hole_ff     <= '0;
         grown_ff    <= '0;
         scanning_ff <= 1'b0;
         from_ff     <= '0;
         chunk_ff    <= '0;
      end else begin
         used_ff     <= used_in;
         hole_ff     <= hole_in;
         grown_ff    <= grown_in;
         scanning_ff <= scanning_in;
         from_ff     <= from_in;
         chunk_ff    <= chunk_in;
      end
   end

   assign stat.scanning = scanning_ff;
   assign stat.used     = used_ff[slot_index];
   assign hole          = hole_ff;
   assign grown         = grown_ff;

   a_hole_within_grown: assert property (@(posedge clock) disable iff (reset)
      hole_ff <= grown_ff)
      else $error("free slot beyond grown region");

   a_grown_bounded: assert property (@(posedge clock) disable iff (reset)
      grown_ff <= GW'(SLOT_COUNT))
      else $error("grown count exceeds table depth");

   a_claim_grows: assert property (@(posedge clock) disable iff (reset)
      (cmd.claim && !scanning_ff) |=> grown_ff != '0)
      else $error("claim left the table empty");

endmodule

// ===== rtl/versioned_handle_table_top.sv =====
// Versioned handle table top level: controller, version and offset memories.
// Depends on vht_pkg and vht_slot_map.
//
// One transaction is taken when start is high and busy is low. Its result
// appears on the rsp_ ports, registered after the checking state and marked by
// rsp_strobe, which is high for exactly one cycle; the receiver cannot stall it.
// On acceptance the slot's version and offset are read from the memories into
// registers; the checking state then checks and writes back. busy stays high in
// the checking state, so a new transaction is not taken while one is checked.
// An add that takes a slot also rescans the use bitmap for the next free slot,
// eight slots a cycle, which keeps busy high until the scan ends (an add that
// takes the last slot does not rescan). No clearing pass runs after reset.
module versioned_handle_table_top
   import vht_pkg::*;
#(
   parameter int SLOT_COUNT   = 64,
   parameter int VERSION_BITS = 32,
   parameter int OFFSET_BITS  = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_opcode,
   input  logic [5:0]  req_slot_index,
   input  logic [31:0] req_handle_version,
   input  logic [31:0] req_position,
   output logic        rsp_strobe,
   output logic [5:0]  rsp_result_index,
   output logic [31:0] rsp_result_version,
   output logic [31:0] rsp_result_offset,
   output logic [2:0]  rsp_status
);

   localparam int AW = $clog2(SLOT_COUNT);
   localparam int GW = $clog2(SLOT_COUNT + 1);
   localparam int VB = VERSION_BITS;
   localparam int OB = OFFSET_BITS;

   state_type state_ff, state_in;

   logic [VB-1:0] ver_mem [SLOT_COUNT];
   logic [OB-1:0] off_mem [SLOT_COUNT];
   logic [VB-1:0] ver_rd_ff;
   logic [OB-1:0] off_rd_ff;

   logic [2:0]    op_ff;
   logic [5:0]    idx_ff;
   logic [AW-1:0] addr_ff;
   logic [VB-1:0] ver_ff;
   logic [OB-1:0] pos_ff;
   logic [VB-1:0] last_version_ff, last_version_in;

   logic          rsp_strobe_ff;
   logic [5:0]    rsp_index_ff, rsp_index_in;
   logic [31:0]   rsp_version_ff, rsp_version_in;
   logic [31:0]   rsp_offset_ff, rsp_offset_in;
   status_type    rsp_status_ff, rsp_status_in;

   logic          accept;
   logic          exec;
   logic [AW+5:0] req_idx_wide;
   logic [AW+5:0] hole_idx_wide;
   logic [VB+31:0] req_ver_wide;
   logic [OB+31:0] req_pos_wide;
   logic [VB+31:0] out_ver_wide;
   logic [OB+31:0] out_off_wide;

   slot_cmd_type  map_cmd;
   slot_stat_type map_stat;
   logic [GW-1:0] hole;
   logic [GW-1:0] grown;

   logic          in_range;
   logic [VB-1:0] stored_ver;
   status_type    strong_sts;
   logic [VB-1:0] new_ver;
   logic          table_full;
   logic          ver_we;
   logic          off_we;
   logic [AW-1:0] wr_addr;
   logic [OB-1:0] off_wdata;
   logic [VB-1:0] out_ver;
   logic [OB-1:0] out_off;

   assign accept        = start && !busy;
   assign exec          = (state_ff == ST_EXEC);
   assign req_idx_wide  = (AW + 6)'(req_slot_index);
   assign req_ver_wide  = (VB + 32)'(req_handle_version);
   assign req_pos_wide  = (OB + 32)'(req_position);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state outputs
   always_comb begin
      unique case (state_ff)
         ST_IDLE: busy = map_stat.scanning;
         ST_EXEC: busy = 1'b1;
         default: busy = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff     <= req_opcode;
         idx_ff    <= req_slot_index;
         addr_ff   <= req_idx_wide[AW-1:0];
         ver_ff    <= req_ver_wide[VB-1:0];
         pos_ff    <= req_pos_wide[OB-1:0];
         ver_rd_ff <= ver_mem[req_idx_wide[AW-1:0]];
         off_rd_ff <= off_mem[req_idx_wide[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (ver_we) begin
         ver_mem[wr_addr] <= new_ver;
      end
      if (off_we) begin
         off_mem[wr_addr] <= off_wdata;
      end
   end

   vht_slot_map #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_slot_map (
      .clock      (clock),
      .reset      (reset),
      .cmd        (map_cmd),
      .slot_index (addr_ff),
      .stat       (map_stat),
      .hole       (hole),
      .grown      (grown)
   );

   assign in_range      = (GW + 6)'(idx_ff) < (GW + 6)'(grown);
   assign stored_ver    = map_stat.used ? ver_rd_ff : '0;
   assign table_full    = (hole == GW'(SLOT_COUNT));
   assign hole_idx_wide = (AW + 6)'(hole[AW-1:0]);

   always_comb begin
      new_ver = last_version_ff + 1'b1;
      if (new_ver == '0) begin
         new_ver = VB'(1);
      end
   end

   always_comb begin
      if (!in_range) begin
         strong_sts = STS_RANGE;
      end else if (!map_stat.used) begin
         strong_sts = STS_UNUSED;
      end else if (stored_ver != ver_ff) begin
         strong_sts = STS_MISMATCH;
      end else begin
         strong_sts = STS_OK;
      end
   end

   always_comb begin
      map_cmd         = '0;
      ver_we          = 1'b0;
      off_we          = 1'b0;
      wr_addr         = addr_ff;
      off_wdata       = pos_ff;
      last_version_in = last_version_ff;
      rsp_index_in    = idx_ff;
      out_ver         = '0;
      out_off         = '0;
      rsp_status_in   = STS_OK;
      case (opcode_type'(op_ff))
         OP_ADD: begin
            if (table_full) begin
               rsp_index_in  = '0;
               rsp_status_in = STS_FULL;
            end else begin
               map_cmd.claim   = exec;
               ver_we          = exec;
               off_we          = exec;
               wr_addr         = hole[AW-1:0];
               last_version_in = new_ver;
               rsp_index_in    = hole_idx_wide[5:0];
               out_ver         = new_ver;
            end
         end
         OP_GET: begin
            rsp_status_in = strong_sts;
            if (strong_sts == STS_OK) begin
               out_off = off_rd_ff;
            end
         end
         OP_REMOVE: begin
            rsp_status_in = strong_sts;
            if (strong_sts == STS_OK) begin
               map_cmd.release_slot = exec;
               off_we               = exec;
               off_wdata            = '0;
            end
         end
         OP_REPLACE: begin
            rsp_status_in = strong_sts;
            off_we        = exec && (strong_sts == STS_OK);
         end
         OP_MAKE_WEAK: begin
            if (!in_range) begin
               rsp_status_in = STS_RANGE;
            end else if (!map_stat.used) begin
               rsp_status_in = STS_UNUSED;
            end else begin
               out_ver = stored_ver;
            end
         end
         OP_TRY_LOOKUP: begin
            if (!in_range) begin
               rsp_status_in = STS_RANGE;
            end else if (stored_ver != ver_ff) begin
               rsp_status_in = STS_STALE;
            end else begin
               out_off = off_rd_ff;
            end
         end
         default: begin
            rsp_index_in = '0;
         end
      endcase
   end

   assign out_ver_wide   = (VB + 32)'(out_ver);
   assign out_off_wide   = (OB + 32)'(out_off);
   assign rsp_version_in = out_ver_wide[31:0];
   assign rsp_offset_in  = out_off_wide[31:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff   <= 1'b0;
         last_version_ff <= '0;
      end else begin
         rsp_strobe_ff <= exec;
         if (exec) begin
            last_version_ff <= last_version_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (exec) begin
         rsp_index_ff   <= rsp_index_in;
         rsp_version_ff <= rsp_version_in;
         rsp_offset_ff  <= rsp_offset_in;
         rsp_status_ff  <= rsp_status_in;
      end
   end

   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_result_index   = rsp_index_ff;
   assign rsp_result_version = rsp_version_ff;
   assign rsp_result_offset  = rsp_offset_ff;
   assign rsp_status         = rsp_status_ff;

   a_accept_to_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_EXEC)
      else $error("accepted transaction not executed");

   a_strobe_from_exec: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff == ST_EXEC))
      else $error("result without an executed transaction");

   a_single_result: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("results on consecutive cycles");

   a_add_not_full: assert property (@(posedge clock) disable iff (reset)
      map_cmd.claim |-> !table_full)
      else $error("slot claimed in a full table");

endmodule

// ===== tb/vht_reply_checker.sv =====
// Reply checker for the versioned handle table: watches request and reply
// transactions, predicts each reply from its own copy of the slot table and
// compares. Depends on vht_pkg.
module vht_reply_checker
   import vht_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [2:0]  req_opcode,
   input  logic [5:0]  req_slot_index,
   input  logic [31:0] req_handle_version,
   input  logic [31:0] req_position,
   input  logic        rsp_strobe,
   input  logic [5:0]  rsp_result_index,
   input  logic [31:0] rsp_result_version,
   input  logic [31:0] rsp_result_offset,
   input  logic [2:0]  rsp_status,
   output int          fail_count,
   output int          outstanding,
   output int          checked_count,
   output int          full_count,
   output int          error_count
);

   localparam int DEPTH = 64;

   typedef struct packed {
      logic [5:0]  slot;
      logic [31:0] tag;
      logic [31:0] offset;
      logic [2:0]  status;
   } reply_type;

   logic [31:0] tag_mem    [DEPTH];
   logic [31:0] offset_mem [DEPTH];
   int          grown_count;
   logic [31:0] version_ctr;
   reply_type   expected_q [$];
   int          fails, checked, fulls, errors;

   function automatic logic [2:0] strong_check(logic [5:0] idx, logic [31:0] ver);
      if (idx >= grown_count) return STS_RANGE;
      if (tag_mem[idx] == '0) return STS_UNUSED;
      if (tag_mem[idx] != ver) return STS_MISMATCH;
      return STS_OK;
   endfunction

   function automatic reply_type apply_request(logic [2:0] op, logic [5:0] idx,
                                               logic [31:0] ver, logic [31:0] pos);
      reply_type   r;
      int          free_slot;
      logic [31:0] next_ver;
      r.slot   = idx;
      r.tag    = '0;
      r.offset = '0;
      r.status = STS_OK;
      case (op)
         OP_ADD: begin
            r.slot = '0;
            next_ver = version_ctr + 32'd1;
            if (next_ver == '0) next_ver = 32'd1;
            free_slot = -1;
            for (int i = 0; i < grown_count; i++)
               if (free_slot < 0 && tag_mem[i] == '0) free_slot = i;
            if (free_slot < 0 && grown_count < DEPTH) begin
               free_slot = grown_count;
               grown_count++;
            end
            if (free_slot < 0) begin
               r.status = STS_FULL;
            end else begin
               version_ctr = next_ver;
               tag_mem[free_slot] = next_ver;
               offset_mem[free_slot] = pos;
               r.slot = free_slot[5:0];
               r.tag = next_ver;
            end
         end
         OP_GET, OP_REMOVE, OP_REPLACE: begin
            r.status = strong_check(idx, ver);
            if (r.status == STS_OK) begin
               case (op)
                  OP_GET: r.offset = offset_mem[idx];
                  OP_REMOVE: begin
                     tag_mem[idx] = '0;
                     offset_mem[idx] = '0;
                  end
                  default: offset_mem[idx] = pos;
               endcase
            end
         end
         OP_MAKE_WEAK: begin
            if (idx >= grown_count) r.status = STS_RANGE;
            else if (tag_mem[idx] == '0) r.status = STS_UNUSED;
            else r.tag = tag_mem[idx];
         end
         OP_TRY_LOOKUP: begin
            if (idx >= grown_count) r.status = STS_RANGE;
            else if (tag_mem[idx] != ver) r.status = STS_STALE;
            else r.offset = offset_mem[idx];
         end
         default: r.slot = '0;
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      reply_type want, got;
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            tag_mem[i] = '0;
            offset_mem[i] = '0;
         end
         grown_count = 0;
         version_ctr = '0;
         expected_q.delete();
         fails = 0;
         checked = 0;
         fulls = 0;
         errors = 0;
      end else begin
         if (rsp_strobe === 1'b1) begin
            got.slot   = rsp_result_index;
            got.tag    = rsp_result_version;
            got.offset = rsp_result_offset;
            got.status = rsp_status;
            if (expected_q.size() == 0) begin
               fails++;
               $display("%0t: reply with none pending: idx %0d ver %h off %h status %0d",
                        $time, got.slot, got.tag, got.offset, got.status);
            end else begin
               want = expected_q.pop_front();
               checked++;
               if (got !== want) begin
                  fails++;
                  $display("%0t: reply mismatch: expected idx %0d ver %h off %h status %0d",
                           $time, want.slot, want.tag, want.offset, want.status);
                  $display("%0t:                 actual   idx %0d ver %h off %h status %0d",
                           $time, got.slot, got.tag, got.offset, got.status);
               end
            end
         end
         if (start === 1'b1 && busy === 1'b0) begin
            want = apply_request(req_opcode, req_slot_index, req_handle_version,
                                 req_position);
            if (want.status == STS_FULL) fulls++;
            if (want.status != STS_OK) errors++;
            expected_q = {expected_q, want};
         end
      end
      fail_count    <= fails;
      outstanding   <= expected_q.size();
      checked_count <= checked;
      full_count    <= fulls;
      error_count   <= errors;
   end

endmodule

// ===== tb/tb.sv =====
// Testbench top for the versioned handle table: clock, reset, directed and
// random request transactions with random gaps, and the verdict.
// Depends on vht_pkg, versioned_handle_table_top and vht_reply_checker.
module tb
   import vht_pkg::*;
();

   localparam int         DEPTH       = 64;
   localparam int         EPOCHS      = 14;
   localparam int         EPOCH_ITEMS = 100;
   localparam logic [2:0] OP_SPARE_LO = 3'd6;
   localparam logic [2:0] OP_SPARE_HI = 3'd7;

   logic        clock, reset, start, busy;
   logic [2:0]  req_opcode;
   logic [5:0]  req_slot_index;
   logic [31:0] req_handle_version, req_position;
   logic        rsp_strobe;
   logic [5:0]  rsp_result_index;
   logic [31:0] rsp_result_version, rsp_result_offset;
   logic [2:0]  rsp_status;
   int          fail_count, outstanding, checked_count, full_count, error_count;

   logic [31:0] live_ver [DEPTH];
   int          seen_slots;

   versioned_handle_table_top uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_opcode(req_opcode), .req_slot_index(req_slot_index),
      .req_handle_version(req_handle_version), .req_position(req_position),
      .rsp_strobe(rsp_strobe), .rsp_result_index(rsp_result_index),
      .rsp_result_version(rsp_result_version), .rsp_result_offset(rsp_result_offset),
      .rsp_status(rsp_status)
   );

   vht_reply_checker reply_chk (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_opcode(req_opcode), .req_slot_index(req_slot_index),
      .req_handle_version(req_handle_version), .req_position(req_position),
      .rsp_strobe(rsp_strobe), .rsp_result_index(rsp_result_index),
      .rsp_result_version(rsp_result_version), .rsp_result_offset(rsp_result_offset),
      .rsp_status(rsp_status),
      .fail_count(fail_count), .outstanding(outstanding),
      .checked_count(checked_count), .full_count(full_count),
      .error_count(error_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #8000000;
      $display("Some tests failed");
      $finish;
   end

   // learn live handles from add and make-weak replies
   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1 && rsp_status == STS_OK &&
          rsp_result_version != '0) begin
         live_ver[rsp_result_index] <= rsp_result_version;
         if (rsp_result_index >= seen_slots) seen_slots <= rsp_result_index + 1;
      end
   end

   task automatic send(input logic [2:0] op, input logic [5:0] idx,
                       input logic [31:0] ver, input logic [31:0] pos);
      req_opcode         <= op;
      req_slot_index     <= idx;
      req_handle_version <= ver;
      req_position       <= pos;
      start              <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic pause(input int cycles);
      if (cycles > 0) begin
         start <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   function automatic int gap_cycles();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   task automatic random_item(input int add_pct);
      logic [2:0]  op;
      logic [5:0]  idx;
      logic [31:0] ver;
      int          roll;
      roll = $urandom_range(0, 99);
      if (roll < 2) op = $urandom_range(0, 1) ? OP_SPARE_LO : OP_SPARE_HI;
      else if (roll < 2 + add_pct) op = OP_ADD;
      else op = 3'($urandom_range(OP_GET, OP_TRY_LOOKUP));
      if ($urandom_range(0, 9) == 0 || seen_slots == 0)
         idx = 6'($urandom_range(0, DEPTH - 1));
      else
         idx = 6'($urandom_range(0, seen_slots - 1));
      roll = $urandom_range(0, 99);
      if (roll < 70) ver = live_ver[idx];
      else if (roll < 80) ver = live_ver[idx] + ($urandom_range(0, 1) ? 32'd1 : -32'd1);
      else if (roll < 88) ver = '0;
      else ver = $urandom;
      send(op, idx, ver, $urandom);
   endtask

   initial begin
      int  add_pct;
      bit  quiet;
      for (int i = 0; i < DEPTH; i++) live_ver[i] = '0;
      seen_slots = 0;
      reset              <= 1'b1;
      start              <= 1'b0;
      req_opcode         <= OP_ADD;
      req_slot_index     <= '0;
      req_handle_version <= '0;
      req_position       <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty table, then handles 0/1, 1/2, 2/3
      send(OP_GET,        6'd0,  32'd0,        32'd0);
      send(OP_TRY_LOOKUP, 6'd63, 32'hFFFFFFFF, 32'hFFFFFFFF);
      send(OP_MAKE_WEAK,  6'd5,  32'd1,        32'd0);
      send(OP_ADD,        6'd63, 32'hFFFFFFFF, 32'hFFFFFFFF);
      send(OP_ADD,        6'd0,  32'd0,        32'd0);
      pause(3);
      send(OP_ADD,        6'd21, 32'h5A5A5A5A, 32'hA5A55A5A);
      send(OP_GET,        6'd0,  32'd1,        32'd0);
      send(OP_GET,        6'd1,  32'd5,        32'd0);
      send(OP_REPLACE,    6'd1,  32'd2,        32'h12345678);
      send(OP_GET,        6'd1,  32'd2,        32'd0);
      send(OP_MAKE_WEAK,  6'd2,  32'd0,        32'd0);
      send(OP_REMOVE,     6'd1,  32'd2,        32'd0);
      pause(1);
      send(OP_GET,        6'd1,  32'd2,        32'd0);
      send(OP_TRY_LOOKUP, 6'd1,  32'd0,        32'd0);
      send(OP_TRY_LOOKUP, 6'd1,  32'd2,        32'd0);
      send(OP_MAKE_WEAK,  6'd1,  32'd2,        32'd0);
      send(OP_REMOVE,     6'd1,  32'd2,        32'd0);
      send(OP_REPLACE,    6'd3,  32'd3,        32'd7);
      send(OP_ADD,        6'd40, 32'd9,        32'h00000001);
      send(OP_TRY_LOOKUP, 6'd0,  32'd1,        32'd0);
      send(OP_GET,        6'd2,  32'hFFFFFFFF, 32'd0);
      send(OP_SPARE_LO,   6'd63, 32'hFFFFFFFF, 32'hFFFFFFFF);
      send(OP_SPARE_HI,   6'd2,  32'd3,        32'd0);
      pause(5);

      for (int e = 0; e < EPOCHS; e++) begin
         case ($urandom_range(0, 2))
            0: add_pct = 80;
            1: add_pct = 45;
            default: add_pct = 15;
         endcase
         if (e == 0) add_pct = 85;
         quiet = ($urandom_range(0, 3) == 0);
         for (int n = 0; n < EPOCH_ITEMS; n++) begin
            random_item(add_pct);
            pause(quiet ? 0 : gap_cycles());
         end
      end

      start <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      $display("Run covered %0d checked replies over fill, churn and drain phases,",
               checked_count);
      $display("with %0d error statuses, %0d of them adds to a full table.",
               error_count, full_count);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
